[sv/mtls_pkg.sv]
// ----------------------------------------------------------------------------
// Markdown table line splitter: shared definitions
// Line length limit, field widths, character codes, the result item layout
// and the saturating helper used by the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mtls_pkg;

    // Line length limit and the widths that follow from it.
    localparam int LINE_MAX   = 4096;
    localparam int POS_W      = $clog2(LINE_MAX + 1);
    localparam int IDX_W      = $clog2(LINE_MAX);

    // Result field widths.
    localparam int FIELD_W    = 12;
    localparam int FIELD_MAX  = (1 << FIELD_W) - 1;
    localparam int WIDE_W     = (POS_W > FIELD_W) ? POS_W : FIELD_W;

    // Stream widths.
    localparam int BYTE_W      = 8;
    localparam int OUT_USED_W  = 4 * FIELD_W + 5;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

    // One item can cause at most three result items.
    localparam int RES_MAX    = 3;
    localparam int NUM_W      = $clog2(RES_MAX + 1);

    // Result queue.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Character codes.
    localparam logic [BYTE_W-1:0] CH_PIPE   = 8'h7C;
    localparam logic [BYTE_W-1:0] CH_DASH   = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;

    typedef enum logic [1:0] {
        ALIGN_LEFT   = 2'd0,
        ALIGN_RIGHT  = 2'd1,
        ALIGN_CENTER = 2'd2
    } t_align;

    typedef enum logic {
        KIND_CELL    = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    // One result item.
    typedef struct packed {
        t_kind                kind;
        logic [FIELD_W-1:0]   cell_number;
        logic [FIELD_W-1:0]   cell_offset;
        logic [FIELD_W-1:0]   cell_length;
        t_align               alignment;
        logic                 row_flag;
        logic                 delimiter_flag;
        logic [FIELD_W-1:0]   cell_total;
        logic                 too_long;
        logic                 last;
    } t_result;

    // The result items of one processed item, in order, and how many are valid.
    typedef struct packed {
        logic [NUM_W-1:0]           num;
        t_result [RES_MAX-1:0]      res;
    } t_push;

    // Saturate a value to the width of a result field.
    function automatic logic [FIELD_W-1:0] clamp_field(input logic [WIDE_W-1:0] v);
        return (v > WIDE_W'(FIELD_MAX)) ? FIELD_W'(FIELD_MAX) : v[FIELD_W-1:0];
    endfunction

endpackage

`default_nettype wire

[sv/markdown_table_line_splitter.sv]
// ----------------------------------------------------------------------------
// Markdown table line splitter
// Path: each item is held in the input register, and its result items then
// pass through the result queue. Throughput: one item per cycle. An item
// waits in the input register only while the result queue lacks room for all
// of its result items; with the output ready the queue drains one item per
// cycle, and otherwise the wait follows the output stalls.
// Reset: synchronous, active low; clears the line state and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module markdown_table_line_splitter (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [7:0] text_byte
    input  wire logic [mtls_pkg::BYTE_W-1:0]        s_axis_tdata,
    // [0] has_byte
    input  wire logic                               s_axis_tuser,
    input  wire logic                               s_axis_tlast,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [11:0] cell_number, [23:12] cell_offset, [35:24] cell_length,
    // [37:36] alignment, [38] row_flag, [39] delimiter_flag,
    // [51:40] cell_total, [52] too_long, [55:53] zero
    output logic [mtls_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // [0] kind
    output logic                                    m_axis_tuser,
    output logic                                    m_axis_tlast
);

    mtls_pkg::t_push                 push;
    logic [mtls_pkg::CNT_W-1:0]      free;
    mtls_pkg::t_result               head;

    // Line parser with its input register.
    mtls_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_in_byte  (s_axis_tdata),
        .i_in_has   (s_axis_tuser),
        .i_in_end   (s_axis_tlast),
        .i_free     (free),
        .o_push     (push)
    );

    // Result queue towards the output stream.
    mtls_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_free  (free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_head  (head)
    );

    // Output item packing.
    assign m_axis_tdata = {{mtls_pkg::OUT_PAD_W{1'b0}}, head.too_long, head.cell_total,
                           head.delimiter_flag, head.row_flag, head.alignment,
                           head.cell_length, head.cell_offset, head.cell_number};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

[sv/mtls_parser.sv]
// ----------------------------------------------------------------------------
// Markdown table line splitter: line parser
// Holds the input register and the per-line state, and turns each item into
// up to three result items (a confirmed cell, a final cell and the summary).
// ----------------------------------------------------------------------------
`default_nettype none

module mtls_parser (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [mtls_pkg::BYTE_W-1:0]   i_in_byte,
    input  wire logic                          i_in_has,
    input  wire logic                          i_in_end,
    input  wire logic [mtls_pkg::CNT_W-1:0]    i_free,
    output mtls_pkg::t_push                    o_push
);

    typedef enum logic {
        PH_LEAD = 1'b0,
        PH_BODY = 1'b1
    } t_phase;

    typedef struct packed {
        logic any;
        logic ns;
        logic fcolon;
        logic lcolon;
        logic prev;
        logic pcolon;
        logic lpipe;
    } t_seg_flags;

    typedef struct packed {
        logic [mtls_pkg::IDX_W-1:0] start;
        logic [mtls_pkg::IDX_W-1:0] first_ns;
        logic [mtls_pkg::IDX_W-1:0] last_ns;
        logic [mtls_pkg::IDX_W-1:0] prev_ns;
        t_seg_flags                 flags;
    } t_seg;

    typedef struct packed {
        logic pipe1;
        logic pipe2;
        logic bad;
        logic dash;
        logic oddws;
        logic too_long;
    } t_line_flags;

    typedef struct packed {
        logic [mtls_pkg::IDX_W-1:0] offset;
        logic [mtls_pkg::IDX_W-1:0] length;
        mtls_pkg::t_align           align;
        logic                       nonempty;
    } t_cell;

    // Whitespace as in the C library: space, tab, LF, VT, FF, CR.
    function automatic logic is_ws(input logic [mtls_pkg::BYTE_W-1:0] c);
        return (c == mtls_pkg::CH_SPACE) ||
               ((c >= mtls_pkg::CH_TAB) && (c <= mtls_pkg::CH_CR));
    endfunction

    // Saturate a position at the last index of a line.
    function automatic logic [mtls_pkg::IDX_W-1:0] sat_idx(
        input logic [mtls_pkg::POS_W-1:0] v
    );
        return (v > mtls_pkg::POS_W'(mtls_pkg::LINE_MAX - 1)) ?
               mtls_pkg::IDX_W'(mtls_pkg::LINE_MAX - 1) : v[mtls_pkg::IDX_W-1:0];
    endfunction

    function automatic logic [mtls_pkg::FIELD_W-1:0] cnt_inc(
        input logic [mtls_pkg::FIELD_W-1:0] c
    );
        return (c == mtls_pkg::FIELD_W'(mtls_pkg::FIELD_MAX)) ?
               c : c + mtls_pkg::FIELD_W'(1);
    endfunction

    // Open a new segment at the given position.
    function automatic t_seg seg_begin(input logic [mtls_pkg::IDX_W-1:0] start);
        t_seg r;
        r       = '0;
        r.start = start;
        return r;
    endfunction

    // Add one content byte to the open segment.
    function automatic t_seg seg_byte(
        input t_seg                        s,
        input logic [mtls_pkg::IDX_W-1:0]  idx,
        input logic [mtls_pkg::BYTE_W-1:0] c
    );
        t_seg r;
        r           = s;
        r.flags.any = 1'b1;
        if (!is_ws(c)) begin
            r.prev_ns      = s.last_ns;
            r.flags.prev   = s.flags.ns;
            r.flags.pcolon = s.flags.lcolon;
            if (!s.flags.ns) begin
                r.first_ns     = idx;
                r.flags.fcolon = (c == mtls_pkg::CH_COLON);
                r.flags.ns     = 1'b1;
            end
            r.last_ns      = idx;
            r.flags.lcolon = (c == mtls_pkg::CH_COLON);
            r.flags.lpipe  = (c == mtls_pkg::CH_PIPE);
        end
        return r;
    endfunction

    // Trimmed extent and alignment of a cell.
    function automatic t_cell make_cell(
        input t_seg                       s,
        input logic                       has,
        input logic [mtls_pkg::IDX_W-1:0] first,
        input logic [mtls_pkg::IDX_W-1:0] final_ns,
        input logic                       fcol,
        input logic                       lcol
    );
        t_cell                      r;
        logic [mtls_pkg::POS_W-1:0] span;
        span       = mtls_pkg::POS_W'(final_ns) - mtls_pkg::POS_W'(first) +
                     mtls_pkg::POS_W'(1);
        r.nonempty = s.flags.any;
        if (has && (final_ns >= first)) begin
            r.offset = first;
            r.length = sat_idx(span);
            r.align  = (fcol && lcol) ? mtls_pkg::ALIGN_CENTER :
                       (lcol ? mtls_pkg::ALIGN_RIGHT : mtls_pkg::ALIGN_LEFT);
        end else begin
            r.offset = s.start;
            r.length = '0;
            r.align  = mtls_pkg::ALIGN_LEFT;
        end
        return r;
    endfunction

    function automatic mtls_pkg::t_result cell_result(
        input t_cell                        c,
        input logic [mtls_pkg::FIELD_W-1:0] number
    );
        mtls_pkg::t_result r;
        r             = '0;
        r.kind        = mtls_pkg::KIND_CELL;
        r.cell_number = number;
        r.cell_offset = mtls_pkg::clamp_field(mtls_pkg::WIDE_W'(c.offset));
        r.cell_length = mtls_pkg::clamp_field(mtls_pkg::WIDE_W'(c.length));
        r.alignment   = c.align;
        return r;
    endfunction

    // Input register.
    logic                          r_in_valid;
    logic [mtls_pkg::BYTE_W-1:0]   r_in_byte;
    logic                          r_in_has;
    logic                          r_in_end;

    // Line state.
    logic [mtls_pkg::POS_W-1:0]    r_pos,      n_pos;
    t_phase                        r_phase,    n_phase;
    logic                          r_esc,      n_esc;
    t_seg                          r_seg,      n_seg;
    t_cell                         r_held,     n_held;
    logic                          r_pipe_unc, n_pipe_unc;
    logic [mtls_pkg::FIELD_W-1:0]  r_cnt,      n_cnt;
    t_line_flags                   r_lf,       n_lf;

    logic                          in_take;
    logic                          proc_fire;
    logic                          ws;
    logic                          body_go;
    logic [mtls_pkg::IDX_W-1:0]    idx;
    logic [mtls_pkg::IDX_W-1:0]    idx_next;
    logic                          emit_a;
    logic                          emit_b;
    t_cell                         cell_a;
    t_cell                         cell_b;
    logic [mtls_pkg::FIELD_W-1:0]  num_a;
    logic [mtls_pkg::FIELD_W-1:0]  num_b;
    t_line_flags                   sum_lf;
    logic [mtls_pkg::FIELD_W-1:0]  sum_total;
    mtls_pkg::t_result             res_a;
    mtls_pkg::t_result             res_b;
    mtls_pkg::t_result             res_s;
    logic [mtls_pkg::NUM_W-1:0]    res_num;

    // Item handshake: the input register frees up when its item is processed.
    assign in_take    = i_in_valid && o_in_ready;
    assign proc_fire  = r_in_valid && (mtls_pkg::CNT_W'(res_num) <= i_free);
    assign o_in_ready = !r_in_valid || proc_fire;

    // Per-item line update, following one item through the line state.
    always_comb begin
        n_pos      = r_pos;
        n_phase    = r_phase;
        n_esc      = r_esc;
        n_seg      = r_seg;
        n_held     = r_held;
        n_pipe_unc = r_pipe_unc;
        n_cnt      = r_cnt;
        n_lf       = r_lf;
        emit_a     = 1'b0;
        emit_b     = 1'b0;
        cell_a     = r_held;
        cell_b     = r_held;
        num_a      = r_cnt;
        num_b      = r_cnt;
        body_go    = 1'b0;
        ws         = is_ws(r_in_byte);
        idx        = sat_idx(r_pos);
        idx_next   = sat_idx(mtls_pkg::POS_W'(idx) + mtls_pkg::POS_W'(1));

        if (r_in_has) begin
            if (r_pos < mtls_pkg::POS_W'(mtls_pkg::LINE_MAX)) begin
                n_pos = r_pos + mtls_pkg::POS_W'(1);
            end else begin
                n_lf.too_long = 1'b1;
            end

            // Delimiter row classification.
            if (!ws) begin
                if (n_lf.oddws) begin
                    n_lf.bad = 1'b1;
                end
                n_lf.oddws = 1'b0;
                if ((r_in_byte != mtls_pkg::CH_PIPE) && (r_in_byte != mtls_pkg::CH_DASH) &&
                    (r_in_byte != mtls_pkg::CH_COLON)) begin
                    n_lf.bad = 1'b1;
                end
                if (r_in_byte == mtls_pkg::CH_DASH) begin
                    n_lf.dash = 1'b1;
                end
            end

            // Leading whitespace is skipped; a leading pipe is dropped.
            if (r_phase == PH_LEAD) begin
                if (!ws) begin
                    n_phase = PH_BODY;
                    if (r_in_byte == mtls_pkg::CH_PIPE) begin
                        n_lf.pipe1 = 1'b1;
                        n_seg      = seg_begin(idx_next);
                    end else begin
                        n_seg   = seg_begin(idx);
                        body_go = 1'b1;
                    end
                end
            end else begin
                if (ws && (r_in_byte != mtls_pkg::CH_SPACE)) begin
                    n_lf.oddws = 1'b1;
                end
                if (r_in_byte == mtls_pkg::CH_PIPE) begin
                    n_lf.pipe2 = 1'b1;
                end
                body_go = 1'b1;
            end

            // Cell body: content after a pipe confirms the held cell.
            if (body_go) begin
                if (!ws && n_pipe_unc) begin
                    emit_a     = 1'b1;
                    cell_a     = n_held;
                    num_a      = n_cnt;
                    n_cnt      = cnt_inc(n_cnt);
                    n_pipe_unc = 1'b0;
                end
                if (n_esc) begin
                    n_esc = 1'b0;
                    n_seg = seg_byte(n_seg, idx, r_in_byte);
                end else if (r_in_byte == mtls_pkg::CH_PIPE) begin
                    n_held     = make_cell(n_seg, n_seg.flags.ns, n_seg.first_ns,
                                           n_seg.last_ns, n_seg.flags.fcolon,
                                           n_seg.flags.lcolon);
                    n_pipe_unc = 1'b1;
                    n_seg      = seg_begin(idx_next);
                end else begin
                    n_seg = seg_byte(n_seg, idx, r_in_byte);
                    if (r_in_byte == mtls_pkg::CH_BSLASH) begin
                        n_esc = 1'b1;
                    end
                end
            end
        end

        // Line end: close the last cell, drop a final pipe, then clear.
        if (r_in_end && (n_phase == PH_BODY)) begin
            if (n_pipe_unc) begin
                if (n_held.nonempty) begin
                    emit_b = 1'b1;
                    cell_b = n_held;
                end
            end else if (n_seg.flags.ns) begin
                emit_b = 1'b1;
                if (n_seg.flags.lpipe) begin
                    cell_b = make_cell(n_seg, n_seg.flags.prev, n_seg.first_ns,
                                       n_seg.prev_ns, n_seg.flags.fcolon,
                                       n_seg.flags.pcolon);
                end else begin
                    cell_b = make_cell(n_seg, 1'b1, n_seg.first_ns, n_seg.last_ns,
                                       n_seg.flags.fcolon, n_seg.flags.lcolon);
                end
            end
            if (emit_b) begin
                num_b = n_cnt;
                n_cnt = cnt_inc(n_cnt);
            end
        end

        sum_lf    = n_lf;
        sum_total = n_cnt;

        if (r_in_end) begin
            n_pos      = '0;
            n_phase    = PH_LEAD;
            n_esc      = 1'b0;
            n_seg      = seg_begin('0);
            n_pipe_unc = 1'b0;
            n_cnt      = '0;
            n_lf       = '0;
        end
    end

    // Result items of this item, packed in order.
    always_comb begin
        res_a = cell_result(cell_a, num_a);
        res_b = cell_result(cell_b, num_b);

        res_s                = '0;
        res_s.kind           = mtls_pkg::KIND_SUMMARY;
        res_s.row_flag       = sum_lf.pipe1 && sum_lf.pipe2;
        res_s.delimiter_flag = sum_lf.pipe1 && !sum_lf.bad && sum_lf.dash;
        res_s.cell_total     = sum_total;
        res_s.too_long       = sum_lf.too_long;
        res_s.last           = 1'b1;

        res_num = r_in_valid ?
                  (mtls_pkg::NUM_W'(emit_a) + mtls_pkg::NUM_W'(emit_b) +
                   mtls_pkg::NUM_W'(r_in_end)) : '0;

        o_push.num    = proc_fire ? res_num : '0;
        o_push.res[0] = emit_a ? res_a : (emit_b ? res_b : res_s);
        o_push.res[1] = (emit_a && emit_b) ? res_b : res_s;
        o_push.res[2] = res_s;
    end

    // Input payload register.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in_byte;
            r_in_has  <= i_in_has;
            r_in_end  <= i_in_end;
        end
    end

    // Control and line state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pos      <= '0;
            r_phase    <= PH_LEAD;
            r_esc      <= 1'b0;
            r_seg      <= '0;
            r_held     <= '0;
            r_pipe_unc <= 1'b0;
            r_cnt      <= '0;
            r_lf       <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (proc_fire) begin
                r_in_valid <= 1'b0;
            end
            if (proc_fire) begin
                r_pos      <= n_pos;
                r_phase    <= n_phase;
                r_esc      <= n_esc;
                r_seg      <= n_seg;
                r_held     <= n_held;
                r_pipe_unc <= n_pipe_unc;
                r_cnt      <= n_cnt;
                r_lf       <= n_lf;
            end
        end
    end

`ifndef ASSERT_OFF
    // A processed line end leaves the line state cleared.
    a_line_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && r_in_end) |=>
        ((r_pos == '0) && (r_cnt == '0) && (r_phase == PH_LEAD) && !r_pipe_unc))
        else $error("line state not cleared after line end");

    // A held cell only exists inside the body, and never with an escape open.
    a_held_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pipe_unc |-> ((r_phase == PH_BODY) && !r_esc))
        else $error("held cell outside the line body");

    // Without a line end an item confirms at most one cell.
    a_mid_line_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && !r_in_end) |-> (o_push.num <= mtls_pkg::NUM_W'(1)))
        else $error("more than one result for a mid-line item");
`endif

endmodule

`default_nettype wire

[sv/mtls_result_fifo.sv]
// ----------------------------------------------------------------------------
// Markdown table line splitter: result queue
// Small register queue that takes up to three result items per cycle from
// the parser and hands them to the output stream one per cycle while it is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module mtls_result_fifo (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire mtls_pkg::t_push             i_push,
    output logic [mtls_pkg::CNT_W-1:0]       o_free,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output mtls_pkg::t_result                o_head
);

    mtls_pkg::t_result               r_mem [mtls_pkg::FIFO_DEPTH];
    logic [mtls_pkg::PTR_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic [mtls_pkg::PTR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [mtls_pkg::CNT_W-1:0]      r_count,  n_count;
    logic                            pop;

    // Head of the queue drives the output stream.
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign o_free  = mtls_pkg::CNT_W'(mtls_pkg::FIFO_DEPTH) - r_count;
    assign pop     = o_valid && i_ready;

    // Pointer and fill level update.
    always_comb begin
        n_wr_ptr = r_wr_ptr + mtls_pkg::PTR_W'(i_push.num);
        n_rd_ptr = r_rd_ptr + mtls_pkg::PTR_W'(pop);
        n_count  = r_count + mtls_pkg::CNT_W'(i_push.num) - mtls_pkg::CNT_W'(pop);
    end

    // Entry writes: the valid result items go to consecutive slots.
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < mtls_pkg::RES_MAX; j++) begin
            if (mtls_pkg::NUM_W'(j) < i_push.num) begin
                r_mem[r_wr_ptr + mtls_pkg::PTR_W'(j)] <= i_push.res[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef ASSERT_OFF
    // The parser never pushes more result items than there is room for.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mtls_pkg::CNT_W'(i_push.num) <= o_free))
        else $error("result queue overflow");

    // The fill level stays within the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= mtls_pkg::CNT_W'(mtls_pkg::FIFO_DEPTH)))
        else $error("result queue fill level out of range");

    // A pop with nothing pushed lowers the fill level by one.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && (i_push.num == '0)) |=> (r_count == $past(r_count) - mtls_pkg::CNT_W'(1)))
        else $error("result queue fill level wrong after pop");
`endif

endmodule

`default_nettype wire

[tb/markdown_table_line_splitter_test.sv]
// ----------------------------------------------------------------------------
// Markdown table line splitter: self-checking testbench
// Streams text lines into the splitter one byte per item and predicts the cell
// and summary results of every accepted item. Each result item from the block
// is checked field by field against the oldest prediction. Directed lines cover
// alignment, escapes, empty lines and extreme byte values. Random table rows,
// delimiter rows and noise follow. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module markdown_table_line_splitter_test;

    localparam int POS_CAP       = mtls_pkg::LINE_MAX - 1;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 10;

    // One input item as the sender presents it.
    typedef struct {
        logic [7:0] ch;
        logic       has;
        logic       fin;
        bit         hold;
    } t_text_item;

    // Trimmed extent of one cell before it is numbered.
    typedef struct {
        int               offset;
        int               length;
        mtls_pkg::t_align align;
        bit               nonempty;
    } t_cell_span;

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [mtls_pkg::BYTE_W-1:0]      s_axis_tdata  = '0;
    logic                             s_axis_tuser  = 1'b0;
    logic                             s_axis_tlast  = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [mtls_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tuser;
    logic                             m_axis_tlast;

    markdown_table_line_splitter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_text_item        text_queue[$];
    mtls_pkg::t_result parse_due[$];
    logic [7:0]        line_buf[$];
    int                queued_items;
    int                total_items;
    int                accepted_items;
    int                fail_count;
    int                cycle_count;
    int                send_gap;
    bit                send_burst;
    int                stall_left;
    bit                stall_burst;

    // Parser state of the line in progress.
    int         line_pos;
    bit         body_started;
    bit         escaping;
    int         seg_base;
    int         seg_first;
    int         seg_last;
    int         seg_prev_last;
    bit         seg_any, seg_ns, seg_fcolon, seg_lcolon, seg_prev, seg_pcolon, seg_lpipe;
    t_cell_span open_cell;
    bit         pipe_pending;
    int         cells_out;
    bit         lead_pipe, inner_pipe, not_delim, saw_dash, odd_space, overlong;

    // Queue appends.
    task automatic buf_add(input logic [7:0] b);
        line_buf = {line_buf, b};
    endtask

    task automatic item_add(input t_text_item it);
        text_queue = {text_queue, it};
    endtask

    task automatic due_add(input mtls_pkg::t_result r);
        parse_due = {parse_due, r};
    endtask

    function automatic int clip(input int v, input int cap);
        return (v > cap) ? cap : v;
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return c == mtls_pkg::CH_SPACE || (c >= mtls_pkg::CH_TAB && c <= mtls_pkg::CH_CR);
    endfunction

    task automatic seg_open(input int start);
        seg_base      = clip(start, POS_CAP);
        seg_first     = 0;
        seg_last      = 0;
        seg_prev_last = 0;
        {seg_any, seg_ns, seg_fcolon, seg_lcolon, seg_prev, seg_pcolon, seg_lpipe} = '0;
    endtask

    task automatic clear_line();
        line_pos     = 0;
        body_started = 1'b0;
        escaping     = 1'b0;
        seg_open(0);
        open_cell    = '{0, 0, mtls_pkg::ALIGN_LEFT, 1'b0};
        pipe_pending = 1'b0;
        cells_out    = 0;
        {lead_pipe, inner_pipe, not_delim, saw_dash, odd_space, overlong} = '0;
    endtask

    // Track the first and last non-space bytes of the current segment, one step
    // of history deep so that a trailing pipe can be dropped at line end.
    task automatic seg_take(input int idx, input logic [7:0] c);
        seg_any = 1'b1;
        if (is_space(c))
            return;
        seg_prev_last = seg_last;
        seg_prev      = seg_ns;
        seg_pcolon    = seg_lcolon;
        if (!seg_ns) begin
            seg_first  = idx;
            seg_fcolon = (c == mtls_pkg::CH_COLON);
            seg_ns     = 1'b1;
        end
        seg_last   = idx;
        seg_lcolon = (c == mtls_pkg::CH_COLON);
        seg_lpipe  = (c == mtls_pkg::CH_PIPE);
    endtask

    function automatic t_cell_span cell_from(input bit has, input int lo, input int hi,
                                             input bit fcol, input bit lcol);
        t_cell_span span;
        span.nonempty = seg_any;
        if (has && hi >= lo) begin
            span.offset = lo;
            span.length = clip(hi - lo + 1, POS_CAP);
            span.align  = (fcol && lcol) ? mtls_pkg::ALIGN_CENTER :
                          (lcol ? mtls_pkg::ALIGN_RIGHT : mtls_pkg::ALIGN_LEFT);
        end else begin
            span.offset = seg_base;
            span.length = 0;
            span.align  = mtls_pkg::ALIGN_LEFT;
        end
        return span;
    endfunction

    task automatic push_cell(input t_cell_span span);
        mtls_pkg::t_result r;
        r             = '0;
        r.kind        = mtls_pkg::KIND_CELL;
        r.cell_number = mtls_pkg::FIELD_W'(clip(cells_out, mtls_pkg::FIELD_MAX));
        r.cell_offset = mtls_pkg::FIELD_W'(clip(span.offset, mtls_pkg::FIELD_MAX));
        r.cell_length = mtls_pkg::FIELD_W'(clip(span.length, mtls_pkg::FIELD_MAX));
        r.alignment   = span.align;
        due_add(r);
        if (cells_out < mtls_pkg::FIELD_MAX)
            cells_out++;
    endtask

    // A byte after the leading whitespace: confirm a held cell, then split or
    // extend the segment.
    task automatic body_byte(input int idx, input logic [7:0] c);
        if (!is_space(c) && pipe_pending) begin
            push_cell(open_cell);
            pipe_pending = 1'b0;
        end
        if (escaping) begin
            escaping = 1'b0;
            seg_take(idx, c);
        end else if (c == mtls_pkg::CH_PIPE) begin
            open_cell    = cell_from(seg_ns, seg_first, seg_last, seg_fcolon, seg_lcolon);
            pipe_pending = 1'b1;
            seg_open(idx + 1);
        end else begin
            seg_take(idx, c);
            if (c == mtls_pkg::CH_BSLASH)
                escaping = 1'b1;
        end
    endtask

    // Predict the result items of one accepted item.
    task automatic parse_item(input logic [7:0] c, input logic has, input logic fin);
        int                idx;
        bit                ws;
        mtls_pkg::t_result r;
        if (has) begin
            idx = clip(line_pos, POS_CAP);
            ws  = is_space(c);
            if (line_pos < mtls_pkg::LINE_MAX)
                line_pos++;
            else
                overlong = 1'b1;
            if (!ws) begin
                if (odd_space)
                    not_delim = 1'b1;
                odd_space = 1'b0;
                if (c != mtls_pkg::CH_PIPE && c != mtls_pkg::CH_DASH &&
                    c != mtls_pkg::CH_COLON)
                    not_delim = 1'b1;
                if (c == mtls_pkg::CH_DASH)
                    saw_dash = 1'b1;
            end
            if (!body_started) begin
                if (!ws) begin
                    body_started = 1'b1;
                    if (c == mtls_pkg::CH_PIPE) begin
                        lead_pipe = 1'b1;
                        seg_open(idx + 1);
                    end else begin
                        seg_open(idx);
                        body_byte(idx, c);
                    end
                end
            end else begin
                if (ws && c != mtls_pkg::CH_SPACE)
                    odd_space = 1'b1;
                if (c == mtls_pkg::CH_PIPE)
                    inner_pipe = 1'b1;
                body_byte(idx, c);
            end
        end
        if (fin) begin
            // The final segment counts only if it holds something; a final
            // pipe is dropped from it.
            if (body_started) begin
                if (pipe_pending) begin
                    if (open_cell.nonempty)
                        push_cell(open_cell);
                end else if (seg_ns) begin
                    if (seg_lpipe)
                        push_cell(cell_from(seg_prev, seg_first, seg_prev_last,
                                            seg_fcolon, seg_pcolon));
                    else
                        push_cell(cell_from(1'b1, seg_first, seg_last,
                                            seg_fcolon, seg_lcolon));
                end
            end
            r                = '0;
            r.kind           = mtls_pkg::KIND_SUMMARY;
            r.row_flag       = lead_pipe && inner_pipe;
            r.delimiter_flag = lead_pipe && !not_delim && saw_dash;
            r.cell_total     = mtls_pkg::FIELD_W'(clip(cells_out, mtls_pkg::FIELD_MAX));
            r.too_long       = overlong;
            r.last           = 1'b1;
            due_add(r);
            clear_line();
        end
    endtask

    task automatic check_field(input string name, input logic [11:0] want,
                               input logic [11:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Stimulus building.
    task automatic put_text(input string s);
        for (int k = 0; k < s.len(); k++)
            buf_add(s[k]);
    endtask

    task automatic put_ws();
        if ($urandom_range(0, 2) == 0)
            buf_add(8'($urandom_range(9, 13)));
        else
            buf_add(mtls_pkg::CH_SPACE);
    endtask

    // Move the line buffer to the item queue, closing it on the last byte or
    // on a bare end marker, with the odd ignored item in between.
    task automatic queue_line(input bit bare_end, input bit hold);
        t_text_item it;
        int         n;
        n = line_buf.size();
        for (int k = 0; k < n; k++) begin
            it.ch   = line_buf[k];
            it.has  = 1'b1;
            it.fin  = (k == n - 1) && !bare_end;
            it.hold = hold && (k == 0);
            item_add(it);
            queued_items++;
            if ($urandom_range(0, 29) == 0)
                item_add('{8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0});
        end
        if (n == 0 || bare_end) begin
            item_add('{8'($urandom_range(0, 255)), 1'b0, 1'b1, hold && n == 0});
            queued_items++;
        end
        line_buf.delete();
    endtask

    // Random lines: mostly table rows and delimiter rows, some noise.
    task automatic random_lines(input int amount, input bit first_hold);
        int stop;
        int roll;
        int ncell;
        bit hold;
        stop = queued_items + amount;
        hold = first_hold;
        while (queued_items < stop) begin
            roll = $urandom_range(0, 9);
            if (roll < 6) begin
                repeat ($urandom_range(0, 2)) put_ws();
                if ($urandom_range(0, 3) != 0)
                    buf_add(mtls_pkg::CH_PIPE);
                ncell = $urandom_range(0, 4);
                for (int c = 0; c < ncell; c++) begin
                    repeat ($urandom_range(0, 4)) begin
                        case ($urandom_range(0, 11))
                            0:       buf_add(mtls_pkg::CH_COLON);
                            1:       buf_add(mtls_pkg::CH_DASH);
                            2, 3:    buf_add(mtls_pkg::CH_SPACE);
                            4:       buf_add(mtls_pkg::CH_BSLASH);
                            5: begin
                                buf_add(mtls_pkg::CH_BSLASH);
                                buf_add(mtls_pkg::CH_PIPE);
                            end
                            6:       put_ws();
                            default: buf_add(8'($urandom_range(8'h61, 8'h7A)));
                        endcase
                    end
                    if (c < ncell - 1 || $urandom_range(0, 2) != 0)
                        buf_add(mtls_pkg::CH_PIPE);
                end
                repeat ($urandom_range(0, 2)) put_ws();
            end else if (roll < 8) begin
                if ($urandom_range(0, 1) == 0)
                    put_ws();
                if ($urandom_range(0, 7) != 0)
                    buf_add(mtls_pkg::CH_PIPE);
                ncell = $urandom_range(1, 4);
                for (int c = 0; c < ncell; c++) begin
                    if ($urandom_range(0, 1) == 0) buf_add(mtls_pkg::CH_SPACE);
                    if ($urandom_range(0, 1) == 0) buf_add(mtls_pkg::CH_COLON);
                    repeat ($urandom_range(1, 3)) buf_add(mtls_pkg::CH_DASH);
                    if ($urandom_range(0, 1) == 0) buf_add(mtls_pkg::CH_COLON);
                    if ($urandom_range(0, 1) == 0) buf_add(mtls_pkg::CH_SPACE);
                    // Now and then spoil the row with a tab or a letter.
                    if ($urandom_range(0, 15) == 0)
                        buf_add(($urandom_range(0, 1) == 0) ? mtls_pkg::CH_TAB : 8'h78);
                    if (c < ncell - 1 || $urandom_range(0, 3) != 0)
                        buf_add(mtls_pkg::CH_PIPE);
                end
                if ($urandom_range(0, 1) == 0)
                    put_ws();
            end else begin
                repeat ($urandom_range(0, 12)) begin
                    if ($urandom_range(0, 3) == 0)
                        buf_add(mtls_pkg::CH_PIPE);
                    else
                        buf_add(8'($urandom_range(0, 255)));
                end
            end
            queue_line($urandom_range(0, 5) == 0, hold);
            hold = ($urandom_range(0, 11) == 0);
        end
    endtask

    // Fill the item queue, apply reset and wait for the block to drain.
    initial begin
        clear_line();

        // Directed lines.
        item_add('{8'hA5, 1'b0, 1'b0, 1'b0});
        queue_line(1'b0, 1'b0);
        put_text("|:-:|-:|:-|");
        queue_line(1'b0, 1'b0);
        put_text("a\\|");
        queue_line(1'b0, 1'b0);
        put_text("x\\");
        queue_line(1'b0, 1'b0);
        put_text(" \t");
        queue_line(1'b0, 1'b0);
        put_text("|");
        queue_line(1'b1, 1'b0);
        buf_add(8'h00);
        buf_add(8'hFF);
        queue_line(1'b0, 1'b0);

        random_lines(180, 1'b1);
        random_lines(180, 1'b1);
        total_items = text_queue.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (accepted_items < total_items || parse_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("markdown_table_line_splitter verification clean");
        else
            $display("markdown_table_line_splitter verification failed");
        $finish;
    end

    // Driver: predict on acceptance, then present the next item after a gap.
    always @(posedge i_clk) begin : drive
        bit         busy;
        t_text_item item;
        if (i_rst_n) begin
            busy = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                parse_item(s_axis_tdata, s_axis_tuser, s_axis_tlast);
                accepted_items++;
                busy = 1'b0;
                send_gap = send_burst ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 39) == 0)
                    send_burst = !send_burst;
            end
            if (!busy) begin
                if (send_gap == 0 && text_queue.size() != 0 &&
                    !(text_queue[0].hold && parse_due.size() != 0)) begin
                    item = text_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= item.ch;
                    s_axis_tuser  <= item.has;
                    s_axis_tlast  <= item.fin;
                end else begin
                    s_axis_tvalid <= 1'b0;
                    if (send_gap > 0)
                        send_gap--;
                end
            end
        end
    end

    // Monitor: check each accepted result item, then stall for a while.
    always @(posedge i_clk) begin : watch
        mtls_pkg::t_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (parse_due.size() == 0) begin
                    $display("%0t: unexpected result item, tdata %h, tuser %b, tlast %b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    fail_count++;
                end else begin
                    want = parse_due.pop_front();
                    check_field("kind", 12'(want.kind), 12'(m_axis_tuser));
                    check_field("cell_number", want.cell_number, m_axis_tdata[11:0]);
                    check_field("cell_offset", want.cell_offset, m_axis_tdata[23:12]);
                    check_field("cell_length", want.cell_length, m_axis_tdata[35:24]);
                    check_field("alignment", 12'(want.alignment), 12'(m_axis_tdata[37:36]));
                    check_field("row_flag", 12'(want.row_flag), 12'(m_axis_tdata[38]));
                    check_field("delimiter_flag", 12'(want.delimiter_flag),
                                12'(m_axis_tdata[39]));
                    check_field("cell_total", want.cell_total, m_axis_tdata[51:40]);
                    check_field("too_long", 12'(want.too_long), 12'(m_axis_tdata[52]));
                    check_field("last", 12'(want.last), 12'(m_axis_tlast));
                end
                stall_left = stall_burst ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 29) == 0)
                    stall_burst = !stall_burst;
            end
            if (stall_left == 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("markdown_table_line_splitter verification failed");
            $finish;
        end
    end

endmodule
